/* design/lru_glyph_tag_cache_assert.svh */
// Assertion macros shared by the glyph tag cache RTL.
`ifndef LRU_GLYPH_TAG_CACHE_ASSERT_SVH
`define LRU_GLYPH_TAG_CACHE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define LGTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define LGTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lgtc_pkg.sv */
// Package with sizes and state type of the glyph tag cache.
package lgtc_pkg;

  localparam int unsigned ENTRIES = 512;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CODE_W  = 21;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned SLOT_W  = 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } lgtc_state_e;

endpackage

/* design/lgtc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module lgtc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lru_glyph_tag_cache.sv */
// Fully associative glyph tag store with timestamp LRU replacement.
//
// Channel | Direction | Handshake              | Beat contents
// in      | input     | in_valid_i/in_ready_o  | mode_i, code_value_i, size_px_i
// out     | output    | out_valid_o/out_ready_i| hit_o, slot_o, evicted_o, evicted_code_o,
//         |           |                        | flushed_o
//
// A lookup goes from its accepting edge through S_SCAN, S_WRITE and S_DONE to the output
// register, and skips S_SCAN when the store is empty; the scan reads one entry per cycle
// from the code and stamp memories, which share one read address. A set-size beat goes
// straight to S_DONE. The next beat is accepted once the block is back in S_IDLE.
// Reset clears the fill count, sets the use counter to 1 and the size to 0; the
// memories are not cleared. The next beat is taken while a result waits in the
// output register; a finished result stalls only when that register is still full.
module lru_glyph_tag_cache (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic [lgtc_pkg::CODE_W-1:0]      code_value_i,
  input  logic [lgtc_pkg::SIZE_W-1:0]      size_px_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [lgtc_pkg::SLOT_W-1:0]      slot_o,
  output logic                             evicted_o,
  output logic [lgtc_pkg::CODE_W-1:0]      evicted_code_o,
  output logic                             flushed_o
);

  localparam int unsigned IDX_W   = lgtc_pkg::IDX_W;
  localparam int unsigned CNT_W   = lgtc_pkg::CNT_W;
  localparam int unsigned CODE_W  = lgtc_pkg::CODE_W;
  localparam int unsigned STAMP_W = lgtc_pkg::STAMP_W;
  localparam int unsigned SIZE_W  = lgtc_pkg::SIZE_W;
  localparam int unsigned SLOT_W  = lgtc_pkg::SLOT_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(lgtc_pkg::ENTRIES);

  lgtc_pkg::lgtc_state_e state_q, state_d;

  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [STAMP_W-1:0] ctr_q, ctr_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               p_v_q, p_v_d;
  logic [IDX_W-1:0]   p_idx_q, p_idx_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;

  logic [CODE_W-1:0]  code_q, code_d;
  logic [IDX_W-1:0]   match_q, match_d;
  logic [STAMP_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]   victim_q, victim_d;
  logic [CODE_W-1:0]  vcode_q, vcode_d;

  logic               res_hit_q, res_hit_d;
  logic [IDX_W-1:0]   res_slot_q, res_slot_d;
  logic               res_ev_q, res_ev_d;
  logic [CODE_W-1:0]  res_ecode_q, res_ecode_d;
  logic               res_fl_q, res_fl_d;

  logic               out_hit_q, out_hit_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic               out_ev_q, out_ev_d;
  logic [CODE_W-1:0]  out_ecode_q, out_ecode_d;
  logic               out_fl_q, out_fl_d;

  logic               ram_re;
  logic               code_we;
  logic               stamp_we;
  logic [IDX_W-1:0]   waddr;
  logic [CODE_W-1:0]  rd_code;
  logic [STAMP_W-1:0] rd_stamp;

  lgtc_ram #(
    .Width(CODE_W),
    .Depth(lgtc_pkg::ENTRIES)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (code_we),
    .waddr_i(waddr),
    .wdata_i(code_q),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(rd_code)
  );

  lgtc_ram #(
    .Width(STAMP_W),
    .Depth(lgtc_pkg::ENTRIES)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (stamp_we),
    .waddr_i(waddr),
    .wdata_i(ctr_q),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(rd_stamp)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ctr_d       = ctr_q;
    size_d      = size_q;
    rd_idx_d    = rd_idx_q;
    p_v_d       = 1'b0;
    p_idx_d     = rd_idx_q[IDX_W-1:0];
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    code_d      = code_q;
    match_d     = match_q;
    best_d      = best_q;
    victim_d    = victim_q;
    vcode_d     = vcode_q;
    res_hit_d   = res_hit_q;
    res_slot_d  = res_slot_q;
    res_ev_d    = res_ev_q;
    res_ecode_d = res_ecode_q;
    res_fl_d    = res_fl_q;
    out_hit_d   = out_hit_q;
    out_slot_d  = out_slot_q;
    out_ev_d    = out_ev_q;
    out_ecode_d = out_ecode_q;
    out_fl_d    = out_fl_q;
    ram_re      = 1'b0;
    code_we     = 1'b0;
    stamp_we    = 1'b0;
    waddr       = match_q;
    in_ready_o  = 1'b0;

    case (state_q)
      lgtc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_hit_d   = 1'b0;
          res_slot_d  = '0;
          res_ev_d    = 1'b0;
          res_ecode_d = '0;
          res_fl_d    = 1'b0;
          if (mode_i) begin
            // A different size empties the store; the use counter runs on.
            if (size_px_i != size_q) begin
              fill_d   = '0;
              size_d   = size_px_i;
              res_fl_d = 1'b1;
            end
            state_d = lgtc_pkg::S_DONE;
          end else begin
            code_d   = code_value_i;
            found_d  = 1'b0;
            rd_idx_d = '0;
            state_d  = (fill_q == '0) ? lgtc_pkg::S_WRITE : lgtc_pkg::S_SCAN;
          end
        end
      end
      lgtc_pkg::S_SCAN: begin
        if (rd_idx_q < fill_q) begin
          ram_re   = 1'b1;
          p_v_d    = 1'b1;
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (p_v_q) begin
          if (!found_q && rd_code == code_q) begin
            found_d = 1'b1;
            match_d = p_idx_q;
          end
          // Strict compare keeps the first entry among equal oldest stamps.
          if (p_idx_q == '0 || rd_stamp < best_q) begin
            best_d   = rd_stamp;
            victim_d = p_idx_q;
            vcode_d  = rd_code;
          end
          if (CNT_W'(p_idx_q) + CNT_W'(1) == fill_q) begin
            state_d = lgtc_pkg::S_WRITE;
          end
        end
      end
      lgtc_pkg::S_WRITE: begin
        stamp_we = 1'b1;
        ctr_d    = ctr_q + STAMP_W'(1);
        if (found_q) begin
          waddr     = match_q;
          res_hit_d = 1'b1;
        end else if (fill_q < FULL) begin
          waddr   = fill_q[IDX_W-1:0];
          code_we = 1'b1;
          fill_d  = fill_q + CNT_W'(1);
        end else begin
          waddr       = victim_q;
          code_we     = 1'b1;
          res_ev_d    = 1'b1;
          res_ecode_d = vcode_q;
        end
        res_slot_d = waddr;
        state_d    = lgtc_pkg::S_DONE;
      end
      lgtc_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_slot_d  = SLOT_W'(res_slot_q);
          out_ev_d    = res_ev_q;
          out_ecode_d = res_ecode_q;
          out_fl_d    = res_fl_q;
          state_d     = lgtc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lgtc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgtc_pkg::S_IDLE;
      fill_q      <= '0;
      ctr_q       <= STAMP_W'(1);
      size_q      <= '0;
      rd_idx_q    <= '0;
      p_v_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ctr_q       <= ctr_d;
      size_q      <= size_d;
      rd_idx_q    <= rd_idx_d;
      p_v_q       <= p_v_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q     <= p_idx_d;
    code_q      <= code_d;
    match_q     <= match_d;
    best_q      <= best_d;
    victim_q    <= victim_d;
    vcode_q     <= vcode_d;
    res_hit_q   <= res_hit_d;
    res_slot_q  <= res_slot_d;
    res_ev_q    <= res_ev_d;
    res_ecode_q <= res_ecode_d;
    res_fl_q    <= res_fl_d;
    out_hit_q   <= out_hit_d;
    out_slot_q  <= out_slot_d;
    out_ev_q    <= out_ev_d;
    out_ecode_q <= out_ecode_d;
    out_fl_q    <= out_fl_d;
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign slot_o         = out_slot_q;
  assign evicted_o      = out_ev_q;
  assign evicted_code_o = out_ecode_q;
  assign flushed_o      = out_fl_q;

`include "lru_glyph_tag_cache_assert.svh"

  `LGTC_ASSERT(a_fill_bound, fill_q <= FULL, "fill count above capacity")
  `LGTC_ASSERT(a_scan_in_range,
    !p_v_q || (CNT_W'(p_idx_q) < fill_q),
    "scan read beyond fill")
  `LGTC_ASSERT(a_result_kind,
    !out_valid_q || !(out_fl_q && (out_hit_q || out_ev_q)) && !(out_hit_q && out_ev_q),
    "inconsistent result flags")
  `LGTC_ASSERT_NEXT(a_accept_leaves_idle,
    in_valid_i && in_ready_o,
    state_q != lgtc_pkg::S_IDLE,
    "accepted beat left block idle")
  `LGTC_ASSERT_NEXT(a_counter_step,
    state_q == lgtc_pkg::S_WRITE,
    ctr_q == $past(ctr_q) + STAMP_W'(1),
    "use counter did not advance")

endmodule

/* tb/lru_glyph_tag_cache_tb.sv */
// Self-checking testbench of the glyph tag cache with an LRU store model and random flow control.
module lru_glyph_tag_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_LOOKUP   = 1'b0;
  localparam logic MODE_SET_SIZE = 1'b1;

  // First result count at which the receiver holds off, and the second one.
  localparam int HOLD_AT_EARLY = 30;
  localparam int HOLD_AT_LATE  = 900;
  localparam int HOLD_CYCLES   = 1500;
  // Longest lookup is a full scan of the store; leave room after the last beat.
  localparam int TAIL_CYCLES   = 600;

  typedef struct packed {
    logic                        mode;
    logic [lgtc_pkg::CODE_W-1:0] code;
    logic [lgtc_pkg::SIZE_W-1:0] size_px;
    logic                        drain_first;
  } glyph_req_t;

  typedef struct packed {
    logic                        hit;
    logic [lgtc_pkg::SLOT_W-1:0] slot;
    logic                        evicted;
    logic [lgtc_pkg::CODE_W-1:0] evicted_code;
    logic                        flushed;
  } glyph_resp_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic                        mode_i         = MODE_LOOKUP;
  logic [lgtc_pkg::CODE_W-1:0] code_value_i   = '0;
  logic [lgtc_pkg::SIZE_W-1:0] size_px_i      = '0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic                        hit_o;
  logic [lgtc_pkg::SLOT_W-1:0] slot_o;
  logic                        evicted_o;
  logic [lgtc_pkg::CODE_W-1:0] evicted_code_o;
  logic                        flushed_o;

  lru_glyph_tag_cache DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .code_value_i  (code_value_i),
    .size_px_i     (size_px_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .slot_o        (slot_o),
    .evicted_o     (evicted_o),
    .evicted_code_o(evicted_code_o),
    .flushed_o     (flushed_o)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the tag store.
  logic [lgtc_pkg::CODE_W-1:0]  tag_codes [lgtc_pkg::ENTRIES];
  logic [lgtc_pkg::STAMP_W-1:0] tag_stamps[lgtc_pkg::ENTRIES];
  int                           tag_fill  = 0;
  logic [lgtc_pkg::STAMP_W-1:0] use_clock = 64'd1;
  logic [lgtc_pkg::SIZE_W-1:0]  px_size   = '0;

  glyph_req_t  glyph_req_q[$];
  glyph_resp_t cache_resp_q[$];
  int          mismatches   = 0;
  int          results_seen = 0;

  function automatic glyph_resp_t lookup_glyph(glyph_req_t req);
    glyph_resp_t                  resp;
    int                           idx;
    int                           i;
    logic [lgtc_pkg::STAMP_W-1:0] oldest;
    resp = '0;
    if (req.mode == MODE_SET_SIZE) begin
      if (req.size_px != px_size) begin
        tag_fill     = 0;
        px_size      = req.size_px;
        resp.flushed = 1'b1;
      end
    end else begin
      idx = -1;
      for (i = 0; i < tag_fill; i++) begin
        if (tag_codes[i] == req.code) begin
          idx = i;
          break;
        end
      end
      if (idx >= 0) begin
        resp.hit = 1'b1;
      end else begin
        if (tag_fill < lgtc_pkg::ENTRIES) begin
          idx = tag_fill;
          tag_fill++;
        end else begin
          // Victim is the first entry holding the smallest stamp.
          idx    = 0;
          oldest = '1;
          for (i = 0; i < tag_fill; i++) begin
            if (tag_stamps[i] < oldest) begin
              oldest = tag_stamps[i];
              idx    = i;
            end
          end
          resp.evicted      = 1'b1;
          resp.evicted_code = tag_codes[idx];
        end
        tag_codes[idx] = req.code;
      end
      resp.slot       = idx[lgtc_pkg::SLOT_W-1:0];
      tag_stamps[idx] = use_clock;
      use_clock++;
    end
    return resp;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Sender: bursts of beats separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin : driver
    logic       offering;
    glyph_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        req = '{mode: mode_i, code: code_value_i, size_px: size_px_i, drain_first: 1'b0};
        cache_resp_q.push_back(lookup_glyph(req));
        offering = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 25);
        end
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (glyph_req_q.size() != 0 &&
                     !(glyph_req_q[0].drain_first && cache_resp_q.size() != 0)) begin
          req = glyph_req_q.pop_front();
          mode_i       <= req.mode;
          code_value_i <= req.code;
          size_px_i    <= req.size_px;
          offering     = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  // Receiver: stall style changes every so often, with two long hold-offs.
  int rx_style  = 0;
  int rx_cycles = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin : monitor
    glyph_resp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (cache_resp_q.size() == 0) begin
          $display("%0t ns: unexpected result beat: hit %0b slot %0d evicted %0b",
                   $time, hit_o, slot_o, evicted_o);
          $display("%0t ns: unexpected result beat: code 0x%0h flushed %0b",
                   $time, evicted_code_o, flushed_o);
          mismatches++;
        end else begin
          want = cache_resp_q.pop_front();
          check_field("hit", 64'(want.hit), 64'(hit_o));
          check_field("slot", 64'(want.slot), 64'(slot_o));
          check_field("evicted", 64'(want.evicted), 64'(evicted_o));
          check_field("evicted_code", 64'(want.evicted_code), 64'(evicted_code_o));
          check_field("flushed", 64'(want.flushed), 64'(flushed_o));
        end
        results_seen++;
        if (results_seen == HOLD_AT_EARLY || results_seen == HOLD_AT_LATE) begin
          hold_left = HOLD_CYCLES;
        end
      end
      rx_cycles++;
      if (rx_cycles % 97 == 0) begin
        rx_style = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic push_lookup(logic [lgtc_pkg::CODE_W-1:0] code, logic drain = 1'b0);
    glyph_req_q.push_back('{mode: MODE_LOOKUP, code: code,
                            size_px: lgtc_pkg::SIZE_W'($urandom_range(0, 4095)),
                            drain_first: drain});
  endtask

  task automatic push_size(logic [lgtc_pkg::SIZE_W-1:0] size_px, logic drain = 1'b0);
    glyph_req_q.push_back('{mode: MODE_SET_SIZE,
                            code: lgtc_pkg::CODE_W'($urandom_range(0, 21'h1FFFFF)),
                            size_px: size_px, drain_first: drain});
  endtask

  initial begin : stimulus
    logic [lgtc_pkg::CODE_W-1:0] used_codes[$];
    logic [lgtc_pkg::CODE_W-1:0] small_pool[16];
    logic [lgtc_pkg::CODE_W-1:0] code;
    logic [lgtc_pkg::SIZE_W-1:0] run_size;
    int                          pick;
    int                          span;

    // Directed part: field extremes, hits, same-size and differing-size beats.
    push_lookup('0);
    push_lookup(21'h1FFFFF);
    push_lookup(21'h10FFFF);
    push_lookup('0);
    push_lookup(21'h1FFFFF);
    push_size('0);
    push_lookup('0);
    push_size(12'hFFF);
    push_lookup('0);
    push_lookup(21'h10FFFF);
    push_size(12'hFFF);
    push_lookup(21'h10FFFF);
    push_size('0, 1'b1);
    push_lookup(21'h155555);
    push_lookup(21'h0AAAAA);
    push_lookup(21'h155555);
    push_size(12'hAAA);
    push_size(12'h555);
    push_lookup(21'h000001);
    push_lookup(21'h100000);

    // Fill the store past capacity so that evictions start.
    run_size = lgtc_pkg::SIZE_W'($urandom_range(1, 4094));
    push_size(run_size, 1'b1);
    for (int n = 0; n < 600; n++) begin
      if (used_codes.size() != 0 && $urandom_range(0, 4) == 0) begin
        code = used_codes[$urandom_range(0, used_codes.size() - 1)];
      end else begin
        code = lgtc_pkg::CODE_W'($urandom_range(0, 21'h1FFFFF));
      end
      used_codes.push_back(code);
      push_lookup(code);
    end

    // Full store: recent codes mostly hit, new and old ones drive replacement.
    push_lookup(used_codes[used_codes.size() - 1], 1'b1);
    for (int n = 0; n < 350; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        code = lgtc_pkg::CODE_W'($urandom_range(0, 21'h1FFFFF));
      end else if (pick < 16) begin
        span = (used_codes.size() < 64) ? used_codes.size() : 64;
        code = used_codes[used_codes.size() - 1 - $urandom_range(0, span - 1)];
      end else if (pick < 19) begin
        code = used_codes[$urandom_range(0, used_codes.size() - 1)];
      end else begin
        push_size(run_size);
        continue;
      end
      used_codes.push_back(code);
      push_lookup(code);
    end

    // Small working set with frequent size changes, many of them flushing.
    for (int n = 0; n < 16; n++) begin
      small_pool[n] = lgtc_pkg::CODE_W'($urandom_range(0, 21'h1FFFFF));
    end
    push_size(~run_size, 1'b1);
    for (int n = 0; n < 180; n++) begin
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 3))
          0: push_size('0);
          1: push_size(12'hFFF);
          2: push_size(12'd16);
          default: push_size(lgtc_pkg::SIZE_W'($urandom_range(0, 4095)));
        endcase
      end else begin
        push_lookup(small_pool[$urandom_range(0, 15)]);
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sampled at the falling edge so that the driver's updates have settled.
    while (glyph_req_q.size() != 0 || in_valid_i || cache_resp_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && cache_resp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* lru_glyph_tag_cache.f */
+incdir+design
design/lgtc_pkg.sv
design/lgtc_ram.sv
design/lru_glyph_tag_cache.sv
tb/lru_glyph_tag_cache_tb.sv
